[rtl/core/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg: shared definitions for the radix digit converter
// Sizes, field widths and handshake structs between the sequencer and the
// iterative divider.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned MAX_DIGITS    = 32;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned IDX_W         = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = VALUE_WIDTH / BITS_PER_STEP;
  localparam int unsigned STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_W-1:0] RadixMin = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RadixMax = RADIX_W'(16);

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

endpackage

[rtl/core/integer_to_radix_digits_core.sv]
// Sequence: repeated divides by the base on the divider, one digit each, then a
// buffer read before each emitted digit. One transaction at a time: a new
// integer is taken only in idle, after the last digit has been accepted.
// Reset: rst_ni asynchronous, active low; sequencer returns to idle, no outputs.
// The digit buffer needs no clearing pass.
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core: unsigned integer to radix digits
// Divides repeatedly by the base on a single divider, stores digits, then
// emits them most significant first with last on the final digit.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]     radix_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [itrd_pkg::DIGIT_W-1:0]     digit_o,
  output logic                             last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [itrd_pkg::CNT_W-1:0]   count_q, count_d;
  logic [itrd_pkg::IDX_W-1:0]   ptr_q, ptr_d;
  logic [itrd_pkg::RADIX_W-1:0] radix_q, radix_d;

  itrd_pkg::div_req_t div_req;
  itrd_pkg::div_rsp_t div_rsp;

  logic in_xact, out_xact;
  logic wr_en, rd_en;
  logic [itrd_pkg::CNT_W-1:0] count_inc;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xact     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_xact    = out_valid_o && !out_stall_i;
  assign last_o      = (ptr_q == '0);
  assign count_inc   = count_q + 1'b1;

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    ptr_d            = ptr_q;
    radix_d          = radix_q;
    div_req.start    = 1'b0;
    div_req.dividend = value_i;
    div_req.divisor  = radix_q;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_xact) begin
          radix_d         = itrd_pkg::clamp_radix(radix_i);
          div_req.start   = 1'b1;
          div_req.divisor = itrd_pkg::clamp_radix(radix_i);
          count_d         = '0;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          wr_en   = 1'b1;
          count_d = count_inc;
          if (div_rsp.quotient == '0 ||
              count_inc == itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS)) begin
            ptr_d   = count_q[itrd_pkg::IDX_W-1:0];
            state_d = StRead;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end
        end
      end
      StRead: begin
        rd_en   = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_xact) begin
          if (ptr_q == '0) begin
            state_d = StIdle;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
  end

  itrd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  itrd_digit_buffer u_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[itrd_pkg::IDX_W-1:0]),
    .wr_data_i (div_rsp.remainder),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (digit_o)
  );

  // divider only reports while a conversion is running
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDiv)
    else $error("divider result outside division phase");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS))
    else $error("digit count overflow");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> (state_q == StDiv && count_q == '0))
    else $error("accepted transaction did not start division");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xact && last_o) |=> state_q == StIdle)
    else $error("run continued after last digit");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ptr_q < count_q)
    else $error("read pointer beyond stored digits");

endmodule

[rtl/core/itrd_divider.sv]
// ----------------------------------------------------------------------------
// itrd_divider: iterative divide by a small radix
// Restoring long division, BITS_PER_STEP quotient bits per cycle, quotient
// shifted into the dividend register. Done pulses with the result.
// ----------------------------------------------------------------------------
module itrd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itrd_pkg::div_req_t req_i,
  output itrd_pkg::div_rsp_t rsp_o
);

  logic                             busy_q, busy_d;
  logic [itrd_pkg::STEP_W-1:0]      step_q, step_d;
  logic [itrd_pkg::VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [itrd_pkg::RADIX_W-1:0]     rem_q, rem_d;
  logic [itrd_pkg::RADIX_W-1:0]     dvs_q, dvs_d;
  logic                             done_q, done_d;

  logic [itrd_pkg::VALUE_WIDTH-1:0] q_work;
  logic [itrd_pkg::RADIX_W-1:0]     r_work;

  always_comb begin
    q_work = quo_q;
    r_work = rem_q;
    for (int i = 0; i < int'(itrd_pkg::BITS_PER_STEP); i++) begin
      r_work = {r_work[itrd_pkg::RADIX_W-2:0], q_work[itrd_pkg::VALUE_WIDTH-1]};
      q_work = {q_work[itrd_pkg::VALUE_WIDTH-2:0], 1'b0};
      if (r_work >= dvs_q) begin
        r_work    = r_work - dvs_q;
        q_work[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d  = q_work;
      rem_d  = r_work;
      step_d = step_q + 1'b1;
      if (step_q == itrd_pkg::STEP_W'(itrd_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[itrd_pkg::DIGIT_W-1:0];

endmodule

[rtl/core/itrd_digit_buffer.sv]
// ----------------------------------------------------------------------------
// itrd_digit_buffer: digit store
// One write port and one registered read port, least significant digit at
// address zero.
// ----------------------------------------------------------------------------
module itrd_digit_buffer (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [itrd_pkg::IDX_W-1:0]   wr_addr_i,
  input  logic [itrd_pkg::DIGIT_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [itrd_pkg::IDX_W-1:0]   rd_addr_i,
  output logic [itrd_pkg::DIGIT_W-1:0] rd_data_o
);

  logic [itrd_pkg::DIGIT_W-1:0] mem_q [itrd_pkg::MAX_DIGITS];
  logic [itrd_pkg::DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[dv/radix_digit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_checker: scoreboard for the radix digit converter
// Watches both channels, expands every accepted integer into its expected
// digits in the clamped base and compares each emitted digit in order.
// ----------------------------------------------------------------------------
module radix_digit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]     radix_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [itrd_pkg::DIGIT_W-1:0]     digit_i,
  input  logic                             last_i,
  output int                               mismatch_count_o,
  output int                               digits_outstanding_o
);

  typedef struct packed {
    logic [itrd_pkg::DIGIT_W-1:0] digit;
    logic                         last;
  } digit_result_t;

  digit_result_t expected_digits[$];

  initial begin
    mismatch_count_o     = 0;
    digits_outstanding_o = 0;
  end

  task automatic expand_digits(input logic [itrd_pkg::VALUE_WIDTH-1:0] v,
                               input logic [itrd_pkg::RADIX_W-1:0]     r);
    logic [itrd_pkg::VALUE_WIDTH-1:0] rest;
    logic [itrd_pkg::VALUE_WIDTH-1:0] base;
    logic [itrd_pkg::DIGIT_W-1:0]     digit_store[itrd_pkg::MAX_DIGITS];
    int                               n;
    digit_result_t                    res;
    if (r < itrd_pkg::RadixMin) begin
      base = itrd_pkg::VALUE_WIDTH'(itrd_pkg::RadixMin);
    end else if (r > itrd_pkg::RadixMax) begin
      base = itrd_pkg::VALUE_WIDTH'(itrd_pkg::RadixMax);
    end else begin
      base = itrd_pkg::VALUE_WIDTH'(r);
    end
    rest = v;
    n    = 0;
    do begin
      digit_store[n] = itrd_pkg::DIGIT_W'(rest % base);
      rest           = rest / base;
      n++;
    end while (rest != 0 && n < itrd_pkg::MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      res.digit = digit_store[k];
      res.last  = (k == 0);
      expected_digits.push_back(res);
    end
  endtask

  always @(posedge clk_i) begin
    digit_result_t exp_res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expand_digits(value_i, radix_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_digits.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected digit %0d last %0b", $realtime, digit_i, last_i);
          end
          mismatch_count_o++;
        end else begin
          exp_res = expected_digits.pop_front();
          if (exp_res.digit !== digit_i || exp_res.last !== last_i) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: digit mismatch: expected digit %0d last %0b, got digit %0d last %0b",
                       $realtime, exp_res.digit, exp_res.last, digit_i, last_i);
            end
            mismatch_count_o++;
          end
        end
      end
      digits_outstanding_o = expected_digits.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the radix digit converter
// Drives integers and bases with random gaps and receiver stalls, including a
// long output hold-off and a full drain pause; the checker judges every digit.
// ----------------------------------------------------------------------------
module tb;

  logic                             clk      = 1'b0;
  logic                             rst_n    = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [itrd_pkg::VALUE_WIDTH-1:0] value_in = '0;
  logic [itrd_pkg::RADIX_W-1:0]     radix_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [itrd_pkg::DIGIT_W-1:0]     digit_out;
  logic                             last_out;

  int          mismatches;
  int          digits_outstanding;
  int unsigned tx_max_wait   = 4;
  int unsigned rx_max_wait   = 4;
  int unsigned rx_hold_cycles = 0;

  always #10 clk = ~clk;

  integer_to_radix_digits_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value_in),
    .radix_i     (radix_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .digit_o     (digit_out),
    .last_o      (last_out)
  );

  radix_digit_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .value_i              (value_in),
    .radix_i              (radix_in),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .digit_i              (digit_out),
    .last_i               (last_out),
    .mismatch_count_o     (mismatches),
    .digits_outstanding_o (digits_outstanding)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_conversion(input logic [itrd_pkg::VALUE_WIDTH-1:0] v,
                                 input logic [itrd_pkg::RADIX_W-1:0]     r);
    int unsigned gap;
    gap = $urandom_range(tx_max_wait, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value_in = v;
    radix_in = r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [itrd_pkg::VALUE_WIDTH-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(itrd_pkg::VALUE_WIDTH - 1, 0);
    case ($urandom_range(5, 0))
      0, 1:    return $urandom;
      2:       return itrd_pkg::VALUE_WIDTH'($urandom_range(255, 0));
      3:       return itrd_pkg::VALUE_WIDTH'(1) << k;
      4:       return (itrd_pkg::VALUE_WIDTH'(1) << k) - 1;
      default: return ~itrd_pkg::VALUE_WIDTH'($urandom_range(15, 0));
    endcase
  endfunction

  function automatic logic [itrd_pkg::RADIX_W-1:0] pick_radix();
    if ($urandom_range(99, 0) < 85) begin
      return itrd_pkg::RADIX_W'($urandom_range(16, 2));
    end
    return itrd_pkg::RADIX_W'($urandom_range(31, 0));
  endfunction

  // receiver: random stall before each digit, optional long hold-off
  initial begin : rx_side
    int unsigned w;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      w = $urandom_range(rx_max_wait, 0);
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero, unit, all-ones and single-bit values, out-of-range bases, bases 3 to 15
    send_conversion('0, 5'd2);
    send_conversion('0, 5'd16);
    send_conversion('0, 5'd0);
    send_conversion(32'd1, 5'd2);
    send_conversion(32'hFFFF_FFFF, 5'd2);
    send_conversion(32'hFFFF_FFFF, 5'd16);
    send_conversion(32'hFFFF_FFFF, 5'd0);
    send_conversion(32'hFFFF_FFFF, 5'd1);
    send_conversion(32'hFFFF_FFFF, 5'd17);
    send_conversion(32'hFFFF_FFFF, 5'd31);
    send_conversion(32'h8000_0000, 5'd2);
    send_conversion(32'h1234_5678, 5'd16);
    for (int r = 3; r <= 15; r++) begin
      send_conversion($urandom, itrd_pkg::RADIX_W'(r));
    end

    // random, first without idling on either side
    tx_max_wait = 0;
    rx_max_wait = 0;
    for (int i = 0; i < 60; i++) begin
      send_conversion(pick_value(), pick_radix());
    end
    tx_max_wait = 4;
    rx_max_wait = 4;
    for (int i = 0; i < 150; i++) begin
      send_conversion(pick_value(), pick_radix());
    end

    // long receiver hold-off while the sender keeps offering
    rx_hold_cycles = 400;
    tx_max_wait    = 0;
    for (int i = 0; i < 6; i++) begin
      send_conversion(32'hFFFF_FFFF, 5'd2);
    end
    tx_max_wait = 4;

    // full drain before carrying on
    in_valid = 1'b0;
    wait (digits_outstanding == 0);
    repeat (250) @(negedge clk);

    for (int i = 0; i < 179; i++) begin
      send_conversion(pick_value(), pick_radix());
    end
    in_valid = 1'b0;

    wait (digits_outstanding == 0);
    repeat (300) @(negedge clk);
    if (mismatches == 0 && digits_outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
